// ===== rtl/pst_pkg.sv =====
`default_nettype none

package pst_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int KEYWORD_CHARS_DEF = 7;

    localparam int LEN_BITS   = 16;
    localparam int CHAR_BITS  = 7;
    localparam int KW_COUNT   = 7;
    localparam int KW_MAX_LEN = 7;

    localparam int OUT_DEPTH = 4;
    localparam int PTR_BITS  = $clog2(OUT_DEPTH);
    localparam int CNT_BITS  = $clog2(OUT_DEPTH + 1);

    typedef enum logic [4:0] {
        K_EOF       = 5'd0,
        K_INT       = 5'd1,
        K_REAL      = 5'd2,
        K_IDENT     = 5'd3,
        K_BEGIN     = 5'd4,
        K_END       = 5'd5,
        K_DIV       = 5'd6,
        K_PROGRAM   = 5'd7,
        K_VAR       = 5'd8,
        K_INTEGER   = 5'd9,
        K_REALWORD  = 5'd10,
        K_PLUS      = 5'd11,
        K_MINUS     = 5'd12,
        K_MUL       = 5'd13,
        K_SLASH     = 5'd14,
        K_LPAREN    = 5'd15,
        K_RPAREN    = 5'd16,
        K_SEMI      = 5'd17,
        K_DOT       = 5'd18,
        K_COMMA     = 5'd19,
        K_COLON     = 5'd20,
        K_ASSIGN    = 5'd21,
        K_ERROR     = 5'd22
    } t_kind;

    typedef enum logic [6:0] {
        M_IDLE    = 7'b0000001,
        M_COMMENT = 7'b0000010,
        M_INT     = 7'b0000100,
        M_REAL    = 7'b0001000,
        M_WORD    = 7'b0010000,
        M_COLON   = 7'b0100000,
        M_ERROR   = 7'b1000000
    } t_mode;

    typedef struct packed {
        t_kind               kind;
        logic [LEN_BITS-1:0] start;
        logic [LEN_BITS-1:0] len;
        logic                last;
    } t_result;

    // Up to two tokens produced by one input word.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_results;

    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "begin", "end", "div", "program", "var", "integer", "real"
    };
    localparam int KW_LEN [KW_COUNT] = '{5, 3, 3, 7, 3, 7, 4};

    // Character i of keyword k, zero past its end. The string constants are
    // right-justified, so the first character sits in the highest used byte.
    function automatic logic [CHAR_BITS-1:0] kw_char(input int k, input int i);
        logic [CHAR_BITS-1:0] c;
        c = '0;
        if (i < KW_LEN[k]) begin
            c = KW_TEXT[k][(KW_LEN[k] - 1 - i) * 8 +: CHAR_BITS];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pascal_subset_tokenizer.sv =====
`default_nettype none

// Streaming lexer for a small Pascal subset.
// Input channel (i_valid / o_ready): one word per source byte (i_action = 0,
// byte on i_ch), or an end-of-text word (i_action = 1) that flushes the open
// token, sends the end token and returns the scanner to its start state.
// Output channel (o_valid / i_ready): one token per word with kind, start
// offset, length and o_last on the final token caused by an input word.
// An input word is scanned in the cycle it is accepted; its tokens enter a
// four-entry output queue and are presented from the head of that queue.
// Throughput is one input word per cycle while each word gives at most one
// token and the receiver takes every token; a word giving two tokens is read
// out one token at a time through the single read port of the output queue.
// o_ready is high while the queue has room for two tokens, so a stalled
// receiver backs up into the input and nothing is lost.
// Reset is synchronous and active low; it empties the queue and puts the
// scanner between tokens at offset zero.
module pascal_subset_tokenizer #(
    parameter int POSITION_BITS = pst_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_CHARS = pst_pkg::KEYWORD_CHARS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_ch,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [4:0]       o_token_kind,
    output logic [15:0]      o_start_pos,
    output logic [15:0]      o_token_len,
    output logic             o_last
);

    pst_pkg::t_results scan_res;
    pst_pkg::t_result  head;
    logic [pst_pkg::CNT_BITS-1:0] fifo_count;
    logic accept;

    assign o_ready = (fifo_count <= pst_pkg::CNT_BITS'(pst_pkg::OUT_DEPTH - 2));
    assign accept  = i_valid && o_ready;
    assign o_valid = (fifo_count != '0);

    pst_scan #(
        .POSITION_BITS(POSITION_BITS),
        .KEYWORD_CHARS(KEYWORD_CHARS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_action(i_action),
        .i_ch    (i_ch),
        .o_res   (scan_res)
    );

    pst_out_fifo u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (scan_res),
        .i_rd   (o_valid && i_ready),
        .o_head (head),
        .o_count(fifo_count)
    );

    assign o_token_kind = head.kind;
    assign o_start_pos  = head.start;
    assign o_token_len  = head.len;
    assign o_last       = head.last;

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= pst_pkg::CNT_BITS'(pst_pkg::OUT_DEPTH))
        else $error("output queue overflow");

    a_end_gives_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_action |-> scan_res.count != 2'd0)
        else $error("end of text produced no token");

    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == pst_pkg::K_EOF |-> o_last && o_token_len == 16'd0)
        else $error("end token malformed");

    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== rtl/pst_kw_match.sv =====
`default_nettype none

module pst_kw_match #(
    parameter int KEYWORD_CHARS = pst_pkg::KEYWORD_CHARS_DEF
) (
    input  wire logic [pst_pkg::CHAR_BITS-1:0] i_prefix [KEYWORD_CHARS],
    input  wire logic [pst_pkg::LEN_BITS-1:0]  i_word_len,
    output pst_pkg::t_kind                     o_kind
);

    // All keywords are compared in parallel; the first match in table order wins.
    always_comb begin
        logic hit;
        o_kind = pst_pkg::K_IDENT;
        for (int k = pst_pkg::KW_COUNT - 1; k >= 0; k--) begin
            hit = (i_word_len == pst_pkg::LEN_BITS'(pst_pkg::KW_LEN[k]));
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
                if (i_prefix[i] != pst_pkg::kw_char(k, i)) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                o_kind = pst_pkg::t_kind'(5'(int'(pst_pkg::K_BEGIN) + k));
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pst_scan.sv =====
`default_nettype none

module pst_scan #(
    parameter int POSITION_BITS = pst_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_CHARS = pst_pkg::KEYWORD_CHARS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_action,
    input  wire logic [7:0] i_ch,
    output pst_pkg::t_results o_res
);

    localparam int LB = pst_pkg::LEN_BITS;
    localparam int CB = pst_pkg::CHAR_BITS;

    pst_pkg::t_mode r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [LB-1:0]            r_wlen, n_wlen;
    logic [CB-1:0]            r_prefix [KEYWORD_CHARS];
    logic [CB-1:0]            n_prefix [KEYWORD_CHARS];

    pst_pkg::t_kind  kw_kind;
    pst_pkg::t_kind  punct_kind;
    logic            c_digit, c_alpha, c_word, c_space, c_punct;
    logic [CB-1:0]   c_low;
    logic            p_has;
    pst_pkg::t_result p_res;
    pst_pkg::t_result a_res, b_res;
    logic            a_has, b_has;
    logic            brk;

    function automatic logic [LB-1:0] clamp_pos(input logic [POSITION_BITS-1:0] p);
        logic [POSITION_BITS+LB-1:0] w;
        w = (POSITION_BITS + LB)'(p);
        if (w > (POSITION_BITS + LB)'({LB{1'b1}})) begin
            return {LB{1'b1}};
        end
        return w[LB-1:0];
    endfunction

    pst_kw_match #(
        .KEYWORD_CHARS(KEYWORD_CHARS)
    ) u_kw_match (
        .i_prefix  (r_prefix),
        .i_word_len(r_wlen),
        .o_kind    (kw_kind)
    );

    assign c_digit = (i_ch >= 8'h30) && (i_ch <= 8'h39);
    assign c_alpha = ((i_ch >= 8'h61) && (i_ch <= 8'h7a)) || ((i_ch >= 8'h41) && (i_ch <= 8'h5a));
    assign c_word  = c_alpha || c_digit || (i_ch == 8'h5f);
    assign c_space = (i_ch == 8'h20) || ((i_ch >= 8'h09) && (i_ch <= 8'h0d));
    assign c_low   = ((i_ch >= 8'h41) && (i_ch <= 8'h5a)) ? CB'(i_ch + 8'd32) : i_ch[CB-1:0];

    always_comb begin
        c_punct    = 1'b1;
        punct_kind = pst_pkg::K_ERROR;
        unique case (i_ch)
            8'h2b:   punct_kind = pst_pkg::K_PLUS;
            8'h2d:   punct_kind = pst_pkg::K_MINUS;
            8'h2a:   punct_kind = pst_pkg::K_MUL;
            8'h2f:   punct_kind = pst_pkg::K_SLASH;
            8'h28:   punct_kind = pst_pkg::K_LPAREN;
            8'h29:   punct_kind = pst_pkg::K_RPAREN;
            8'h3b:   punct_kind = pst_pkg::K_SEMI;
            8'h2e:   punct_kind = pst_pkg::K_DOT;
            8'h2c:   punct_kind = pst_pkg::K_COMMA;
            default: c_punct = 1'b0;
        endcase
    end

    // Token that is still open and gets closed by the current word.
    always_comb begin
        p_has       = 1'b1;
        p_res       = '0;
        p_res.start = clamp_pos(r_start);
        p_res.len   = r_wlen;
        unique case (r_mode)
            pst_pkg::M_INT:   p_res.kind = pst_pkg::K_INT;
            pst_pkg::M_REAL:  p_res.kind = pst_pkg::K_REAL;
            pst_pkg::M_WORD:  p_res.kind = kw_kind;
            pst_pkg::M_COLON: begin
                p_res.kind = pst_pkg::K_COLON;
                p_res.len  = LB'(1);
            end
            default:          p_has = 1'b0;
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_wlen   = r_wlen;
        n_prefix = r_prefix;
        a_has    = 1'b0;
        b_has    = 1'b0;
        a_res    = '0;
        b_res    = '0;
        brk      = 1'b0;
        if (i_accept) begin
            if (i_action) begin
                // End of text: close the open token, send the end token, restart.
                if (p_has) begin
                    a_has = 1'b1;
                    a_res = p_res;
                    b_has = 1'b1;
                    b_res.kind  = pst_pkg::K_EOF;
                    b_res.start = clamp_pos(r_pos);
                end else begin
                    a_has = 1'b1;
                    a_res.kind  = pst_pkg::K_EOF;
                    a_res.start = clamp_pos(r_pos);
                end
                n_mode  = pst_pkg::M_IDLE;
                n_pos   = '0;
                n_start = '0;
                n_wlen  = '0;
                for (int i = 0; i < KEYWORD_CHARS; i++) begin
                    n_prefix[i] = '0;
                end
            end else begin
                if (r_pos != {POSITION_BITS{1'b1}}) begin
                    n_pos = r_pos + 1'b1;
                end
                unique case (r_mode)
                    pst_pkg::M_ERROR: ;
                    pst_pkg::M_COMMENT: begin
                        if (i_ch == 8'h7d) begin
                            n_mode = pst_pkg::M_IDLE;
                        end
                    end
                    pst_pkg::M_INT: begin
                        if (c_digit || i_ch == 8'h2e) begin
                            if (r_wlen != {LB{1'b1}}) begin
                                n_wlen = r_wlen + 1'b1;
                            end
                            if (!c_digit) begin
                                n_mode = pst_pkg::M_REAL;
                            end
                        end else begin
                            brk = 1'b1;
                        end
                    end
                    pst_pkg::M_REAL: begin
                        if (c_digit) begin
                            if (r_wlen != {LB{1'b1}}) begin
                                n_wlen = r_wlen + 1'b1;
                            end
                        end else begin
                            brk = 1'b1;
                        end
                    end
                    pst_pkg::M_WORD: begin
                        if (c_word) begin
                            for (int i = 0; i < KEYWORD_CHARS; i++) begin
                                if (r_wlen == LB'(i)) begin
                                    n_prefix[i] = c_low;
                                end
                            end
                            if (r_wlen != {LB{1'b1}}) begin
                                n_wlen = r_wlen + 1'b1;
                            end
                        end else begin
                            brk = 1'b1;
                        end
                    end
                    pst_pkg::M_COLON: begin
                        if (i_ch == 8'h3d) begin
                            a_has       = 1'b1;
                            a_res.kind  = pst_pkg::K_ASSIGN;
                            a_res.start = clamp_pos(r_start);
                            a_res.len   = LB'(2);
                            n_mode      = pst_pkg::M_IDLE;
                        end else begin
                            brk = 1'b1;
                        end
                    end
                    pst_pkg::M_IDLE: brk = 1'b1;
                endcase

                if (brk) begin
                    a_has  = p_has;
                    a_res  = p_res;
                    n_mode = pst_pkg::M_IDLE;
                    if (c_space) begin
                        n_mode = pst_pkg::M_IDLE;
                    end else if (i_ch == 8'h7b) begin
                        n_mode = pst_pkg::M_COMMENT;
                    end else if (c_word || i_ch == 8'h3a) begin
                        if (c_digit) begin
                            n_mode = pst_pkg::M_INT;
                        end else if (c_word) begin
                            n_mode = pst_pkg::M_WORD;
                        end else begin
                            n_mode = pst_pkg::M_COLON;
                        end
                        n_start = r_pos;
                        n_wlen  = LB'(1);
                        for (int i = 0; i < KEYWORD_CHARS; i++) begin
                            n_prefix[i] = '0;
                        end
                        n_prefix[0] = c_low;
                    end else begin
                        // Punctuation or a bad byte gives a one-byte token at once.
                        if (p_has) begin
                            b_has       = 1'b1;
                            b_res.kind  = punct_kind;
                            b_res.start = clamp_pos(r_pos);
                            b_res.len   = LB'(1);
                        end else begin
                            a_has       = 1'b1;
                            a_res.kind  = punct_kind;
                            a_res.start = clamp_pos(r_pos);
                            a_res.len   = LB'(1);
                        end
                        if (!c_punct) begin
                            n_mode = pst_pkg::M_ERROR;
                        end
                    end
                end
            end
        end

        if (b_has) begin
            b_res.last = 1'b1;
        end else begin
            a_res.last = a_has;
        end
        o_res.count = {1'b0, a_has} + {1'b0, b_has};
        o_res.r0    = a_res;
        o_res.r1    = b_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= pst_pkg::M_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_wlen  <= '0;
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
                r_prefix[i] <= '0;
            end
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_wlen   <= n_wlen;
            r_prefix <= n_prefix;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pst_out_fifo.sv =====
`default_nettype none

module pst_out_fifo (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pst_pkg::t_results           i_wr,
    input  wire logic                        i_rd,
    output pst_pkg::t_result                 o_head,
    output logic [pst_pkg::CNT_BITS-1:0]     o_count
);

    localparam int PB = pst_pkg::PTR_BITS;
    localparam int CB = pst_pkg::CNT_BITS;

    pst_pkg::t_result r_mem [pst_pkg::OUT_DEPTH];
    logic [PB-1:0] r_wp, n_wp;
    logic [PB-1:0] r_rp, n_rp;
    logic [CB-1:0] r_count, n_count;

    // A word holding two tokens writes two consecutive entries.
    always_comb begin
        n_wp    = r_wp + PB'(i_wr.count);
        n_rp    = i_rd ? r_rp + PB'(1) : r_rp;
        n_count = r_count + CB'(i_wr.count) - CB'(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.count != 2'd0) begin
            r_mem[r_wp] <= i_wr.r0;
        end
        if (i_wr.count == 2'd2) begin
            r_mem[r_wp + PB'(1)] <= i_wr.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

endmodule

`default_nettype wire
